FILE: sv/vbus_drop_compensation_tracker_macros.svh
// Assertion macros used by the tracker's top-level RTL file.
`ifndef VBUS_DROP_COMPENSATION_TRACKER_MACROS_SVH
`define VBUS_DROP_COMPENSATION_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define VDCT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("vdct assertion failed");
`define VDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vdct assertion failed");
`else
`define VDCT_ASSERT(label, clk, rst_n, prop)
`define VDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/vdct_pkg.sv
// Package with widths, reset values, register indexes and shared types of the tracker.
package vdct_pkg;

	localparam int CUR_W      = 8;
	localparam int VOLT_W     = 8;
	localparam int LEVEL_W    = 4;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam logic [VOLT_W-1:0]  LVT_RESET           = 8'h5d;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX_RESET     = 4'd7;
	localparam logic [COUNT_W-1:0] DECLINE_LIMIT_RESET = 4'd3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_VOLTAGE_THRESHOLD = 2'd0,
		REG_LEVEL_MAX             = 2'd1,
		REG_DECLINE_LIMIT         = 2'd2
	} cfg_reg_t;

	// Control handed to every history cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} hist_ctl_t;

endpackage

FILE: sv/vdct_if.sv
// Stream and configuration interfaces of the tracker.
interface vdct_sample_if;
	logic                        valid;
	logic                        ready;
	logic [vdct_pkg::CUR_W-1:0]  bus_cur;
	logic [vdct_pkg::VOLT_W-1:0] bus_volt;
	modport source (output valid, output bus_cur, output bus_volt, input ready);
	modport sink (input valid, input bus_cur, input bus_volt, output ready);
endinterface

interface vdct_result_if;
	logic                         valid;
	logic                         ready;
	logic [vdct_pkg::LEVEL_W-1:0] comp_level;
	modport source (output valid, output comp_level, input ready);
	modport sink (input valid, input comp_level, output ready);
endinterface

interface vdct_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vdct_pkg::CFG_IDX_W-1:0]  index;
	logic [vdct_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/vdct_hist_cell.sv
// One entry of the current history chain: takes its neighbor's value, or zero when cleared, on every accepted beat.
module vdct_hist_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vdct_pkg::hist_ctl_t        ctl,
	input  logic [vdct_pkg::CUR_W-1:0] din,
	output logic [vdct_pkg::CUR_W-1:0] dout
);

	logic [vdct_pkg::CUR_W-1:0] val_q;

	// Shift in the neighbor's value, or drop to zero when the history is cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.shift) begin
			val_q <= ctl.clear ? '0 : din;
		end
	end

	assign dout = val_q;

endmodule

FILE: sv/vbus_drop_compensation_tracker.sv
// Top level of the bus drop compensation tracker.
// The tracker takes one current and voltage sample per beat and accepts a new sample in
// every cycle; a result, when the sample causes one, sits in the output register from the
// cycle after the accept until it is taken, and the input stalls only while that register
// is full and not being drained. The one-cycle rate is set by the history chain, which
// shifts all cells at once, and by a running window sum that is updated with one subtract
// and one add per sample, so the average test is a single compare against one more than
// the current, times depth. Reset clears the history directly; there is no clearing pass.
`include "vbus_drop_compensation_tracker_macros.svh"

module vbus_drop_compensation_tracker #(
	parameter int HISTORY_DEPTH = vdct_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	vdct_cfg_if.sink       cfg,
	vdct_sample_if.sink    sample,
	vdct_result_if.source  result
);

	localparam int CUR_W   = vdct_pkg::CUR_W;
	localparam int LEVEL_W = vdct_pkg::LEVEL_W;
	localparam int COUNT_W = vdct_pkg::COUNT_W;
	localparam int SUM_W   = CUR_W + $clog2(HISTORY_DEPTH);
	localparam int CMP_W   = SUM_W + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'((2 ** CUR_W - 1) * HISTORY_DEPTH);

	// Tracking phase, one-hot.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_SETTLED = 3'b010,
		PH_STEPPED = 3'b100
	} phase_t;

	logic [vdct_pkg::VOLT_W-1:0] lvt_q;
	logic [LEVEL_W-1:0]          level_max_q;
	logic [COUNT_W-1:0]          decline_limit_q;

	logic [CUR_W-1:0]   last_q, last_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] decline_q, decline_d;
	logic [SUM_W-1:0]   sum_q, sum_next;

	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_level_q;

	logic                 accept;
	logic                 emit;
	logic                 clr_hist;
	vdct_pkg::hist_ctl_t  hist_ctl;
	logic [CUR_W-1:0]     hist [HISTORY_DEPTH];

	logic [CUR_W-1:0]   cur;
	logic [CUR_W-1:0]   cur_m1;
	logic [CMP_W-1:0]   avg_thr;
	logic               below_avg;
	logic               lvl_sat;
	logic [LEVEL_W-1:0] lvl_raise;
	logic [LEVEL_W-1:0] lvl_lower;

	// Configuration writes; indexes past the list are taken and ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvt_q           <= vdct_pkg::LVT_RESET;
			level_max_q     <= vdct_pkg::LEVEL_MAX_RESET;
			decline_limit_q <= vdct_pkg::DECLINE_LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				vdct_pkg::REG_LOW_VOLTAGE_THRESHOLD: lvt_q <= cfg.data;
				vdct_pkg::REG_LEVEL_MAX: level_max_q <= cfg.data[LEVEL_W-1:0];
				vdct_pkg::REG_DECLINE_LIMIT: decline_limit_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input is taken whenever the output register is free or drains this cycle.
	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// History chain: cell zero holds the oldest entry, the last cell takes last_q.
	assign hist_ctl.shift = accept;
	assign hist_ctl.clear = clr_hist;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
		if (i == HISTORY_DEPTH - 1) begin : g_tail
			vdct_hist_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (hist_ctl),
				.din   (last_q),
				.dout  (hist[i])
			);
		end else begin : g_body
			vdct_hist_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (hist_ctl),
				.din   (hist[i+1]),
				.dout  (hist[i])
			);
		end
	end

	// Running window sum after this beat's shift; average >= current + 1 iff
	// sum >= (current + 1) * depth.
	assign cur       = sample.bus_cur;
	assign cur_m1    = cur - CUR_W'(1);
	assign sum_next  = sum_q - SUM_W'(hist[0]) + SUM_W'(last_q);
	assign avg_thr   = CMP_W'((CMP_W'(cur) + CMP_W'(1)) * CMP_W'(HISTORY_DEPTH));
	assign below_avg = CMP_W'(sum_next) >= avg_thr;

	// Saturating raise and floor-at-zero lower of the level.
	assign lvl_sat   = level_q >= level_max_q;
	assign lvl_raise = lvl_sat ? level_max_q : level_q + LEVEL_W'(1);
	assign lvl_lower = (level_q != '0) ? level_q - LEVEL_W'(1) : level_q;

	// Per-sample decision.
	always_comb begin
		last_d    = last_q;
		level_d   = level_q;
		phase_d   = phase_q;
		decline_d = decline_q;
		emit      = 1'b0;
		clr_hist  = 1'b0;
		if (cur == '0) begin
			last_d  = '0;
			phase_d = PH_IDLE;
			if (level_q != '0) begin
				level_d = '0;
				emit    = 1'b1;
			end
		end else if (sample.bus_volt < lvt_q) begin
			last_d    = cur;
			phase_d   = PH_IDLE;
			decline_d = '0;
			level_d   = lvl_raise;
			emit      = !lvl_sat;
		end else if (phase_q == PH_IDLE) begin
			phase_d   = PH_STEPPED;
			decline_d = '0;
			level_d   = lvl_raise;
			emit      = !lvl_sat;
		end else if (last_q < cur_m1) begin
			last_d    = cur;
			phase_d   = PH_IDLE;
			decline_d = '0;
		end else if (last_q > cur && phase_q == PH_STEPPED) begin
			last_d    = cur;
			phase_d   = PH_SETTLED;
			decline_d = '0;
			level_d   = lvl_lower;
			emit      = 1'b1;
		end else if (below_avg) begin
			last_d  = cur;
			phase_d = PH_SETTLED;
			if (decline_q >= decline_limit_q) begin
				decline_d = '0;
				clr_hist  = 1'b1;
				level_d   = lvl_lower;
				emit      = 1'b1;
			end else begin
				decline_d = decline_q + COUNT_W'(1);
			end
		end else begin
			last_d    = cur;
			phase_d   = PH_SETTLED;
			decline_d = '0;
		end
	end

	// Tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			level_q   <= '0;
			phase_q   <= PH_IDLE;
			decline_q <= '0;
			sum_q     <= '0;
		end else if (accept) begin
			last_q    <= last_d;
			level_q   <= level_d;
			phase_q   <= phase_d;
			decline_q <= decline_d;
			sum_q     <= clr_hist ? '0 : sum_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_level_q <= level_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.comp_level = out_level_q;

	// Checks.
	`VDCT_ASSERT(a_stall_when_full, clk, arst_n, !(result.valid && !result.ready) || !sample.ready)
	`VDCT_ASSERT(a_sum_in_range, clk, arst_n, sum_q <= SUM_MAX)
	`VDCT_ASSERT_NEXT(a_clear_zeroes_sum, clk, arst_n, accept && clr_hist, sum_q == '0)
	`VDCT_ASSERT_NEXT(a_zero_current_result, clk, arst_n, accept && emit && cur == '0, result.valid && result.comp_level == '0)

endmodule
